FILE: src/lscd_pkg.sv
// Shared constants, register indexes and types for the line sensor centroid detector.
// Depends on nothing; every other file of the block imports it.
package lscd_pkg;

	localparam int SAMPLE_BITS_DEF   = 10;
	localparam int FRACTION_BITS_DEF = 4;
	localparam int NUM_SAMPLES       = 8;
	localparam int NUM_PAIRS         = 4;
	localparam int WEIGHT_W          = 16;
	localparam int THRESH_W          = 10;
	localparam int COUNT_W           = 4;
	localparam int OFFSET_W          = 20;
	localparam int CFG_INDEX_W       = 3;
	localparam int CFG_DATA_W        = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_OUTER    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SECOND   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_THIRD    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_INNER    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_THRESHOLD  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CROSS_MIN_COUNT = 3'd5;

	localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 10'd500;
	localparam logic [COUNT_W-1:0]  CROSS_MIN_RESET = 4'd3;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
	localparam logic [OFFSET_W-1:0] OFFSET_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight_outer;
		logic signed [WEIGHT_W-1:0] weight_second;
		logic signed [WEIGHT_W-1:0] weight_third;
		logic signed [WEIGHT_W-1:0] weight_inner;
		logic [THRESH_W-1:0]        line_threshold;
		logic [COUNT_W-1:0]         cross_min_count;
	} cfg_t;

	typedef struct packed {
		logic at_intersection;
		logic centred;
		logic no_signal;
	} flags_t;

endpackage

FILE: src/line_sensor_centroid_detector.sv
// Pipeline: 5 front stages, 20 divider stages and 1 output register; throughput is one item
// per cycle while the output is not stalled.
// The divider develops one quotient bit per stage, which sets the pipeline depth.
// A stalled output holds its item while earlier stages keep filling.
// Reset clears every valid bit and loads the configuration registers with their reset values.
// Top level of the line sensor centroid detector; depends on lscd_pkg, lscd_front and
// lscd_div_stage.
module line_sensor_centroid_detector #(
	parameter int SAMPLE_BITS   = lscd_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = lscd_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [lscd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lscd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              sample_a,
	input  logic [SAMPLE_BITS-1:0]              sample_b,
	input  logic [SAMPLE_BITS-1:0]              sample_c,
	input  logic [SAMPLE_BITS-1:0]              sample_d,
	input  logic [SAMPLE_BITS-1:0]              sample_e,
	input  logic [SAMPLE_BITS-1:0]              sample_f,
	input  logic [SAMPLE_BITS-1:0]              sample_g,
	input  logic [SAMPLE_BITS-1:0]              sample_h,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lscd_pkg::OFFSET_W-1:0] line_offset,
	output logic                                at_intersection,
	output logic                                centred,
	output logic                                no_signal
);
	import lscd_pkg::*;

	localparam int DEN_W = SAMPLE_BITS + 3;

	cfg_t                cfg_q;

	logic                dv    [0:OFFSET_W];
	logic                dr    [0:OFFSET_W];
	flags_t              dfl   [0:OFFSET_W];
	logic                dneg  [0:OFFSET_W];
	logic                dovf  [0:OFFSET_W];
	logic [DEN_W-1:0]    drem  [0:OFFSET_W];
	logic [OFFSET_W-1:0] dquo  [0:OFFSET_W];
	logic [OFFSET_W-1:0] dlow  [0:OFFSET_W];
	logic [DEN_W-1:0]    dden  [0:OFFSET_W];

	logic                out_rdy;
	logic [OFFSET_W-1:0] offset_c;
	logic                valid_q;
	logic [OFFSET_W-1:0] offset_q;
	flags_t              flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight_outer    <= '0;
			cfg_q.weight_second   <= '0;
			cfg_q.weight_third    <= '0;
			cfg_q.weight_inner    <= '0;
			cfg_q.line_threshold  <= THRESHOLD_RESET;
			cfg_q.cross_min_count <= CROSS_MIN_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WEIGHT_OUTER:    cfg_q.weight_outer    <= cfg_data;
				REG_WEIGHT_SECOND:   cfg_q.weight_second   <= cfg_data;
				REG_WEIGHT_THIRD:    cfg_q.weight_third    <= cfg_data;
				REG_WEIGHT_INNER:    cfg_q.weight_inner    <= cfg_data;
				REG_LINE_THRESHOLD:  cfg_q.line_threshold  <= cfg_data[THRESH_W-1:0];
				REG_CROSS_MIN_COUNT: cfg_q.cross_min_count <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	lscd_front #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample_a (sample_a),
		.sample_b (sample_b),
		.sample_c (sample_c),
		.sample_d (sample_d),
		.sample_e (sample_e),
		.sample_f (sample_f),
		.sample_g (sample_g),
		.sample_h (sample_h),
		.out_valid(dv[0]),
		.out_ready(dr[0]),
		.out_flags(dfl[0]),
		.out_neg  (dneg[0]),
		.out_ovf  (dovf[0]),
		.out_rem  (drem[0]),
		.out_low  (dlow[0]),
		.out_den  (dden[0])
	);

	assign dquo[0] = '0;

	for (genvar g = 0; g < OFFSET_W; g++) begin : g_div
		lscd_div_stage #(
			.DEN_W(DEN_W)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv[g]),
			.in_ready (dr[g]),
			.in_flags (dfl[g]),
			.in_neg   (dneg[g]),
			.in_ovf   (dovf[g]),
			.in_rem   (drem[g]),
			.in_quo   (dquo[g]),
			.in_low   (dlow[g]),
			.in_den   (dden[g]),
			.out_valid(dv[g+1]),
			.out_ready(dr[g+1]),
			.out_flags(dfl[g+1]),
			.out_neg  (dneg[g+1]),
			.out_ovf  (dovf[g+1]),
			.out_rem  (drem[g+1]),
			.out_quo  (dquo[g+1]),
			.out_low  (dlow[g+1]),
			.out_den  (dden[g+1])
		);
	end

	// Apply the sign to the quotient magnitude and clamp to the offset range; an empty frame gives zero.
	always_comb begin
		if (dfl[OFFSET_W].no_signal) begin
			offset_c = '0;
		end else if (dovf[OFFSET_W]) begin
			offset_c = dneg[OFFSET_W] ? OFFSET_MIN : OFFSET_MAX;
		end else if (!dneg[OFFSET_W]) begin
			offset_c = dquo[OFFSET_W][OFFSET_W-1] ? OFFSET_MAX : dquo[OFFSET_W];
		end else begin
			offset_c = (dquo[OFFSET_W] > OFFSET_MIN) ? OFFSET_MIN : OFFSET_W'(-dquo[OFFSET_W]);
		end
	end

	assign out_rdy      = !valid_q || out_ready;
	assign dr[OFFSET_W] = out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_rdy) begin
			valid_q <= dv[OFFSET_W];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			offset_q <= offset_c;
			flags_q  <= dfl[OFFSET_W];
		end
	end

	assign out_valid       = valid_q;
	assign line_offset     = offset_q;
	assign at_intersection = flags_q.at_intersection;
	assign centred         = flags_q.centred;
	assign no_signal       = flags_q.no_signal;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && flags_q.no_signal |-> offset_q == '0)
		else $error("empty frame gave a nonzero offset");

	assert property (@(posedge clk) disable iff (!arst_n)
		dv[OFFSET_W] && dr[OFFSET_W] |=> valid_q)
		else $error("item leaving the divider was lost");

endmodule

FILE: src/lscd_front.sv
// Front pipeline, stages s1 to s5: pair differences, sample sum and lit count, weighted
// products, accumulation, magnitude and the divider setup. Depends on lscd_pkg.
module lscd_front #(
	parameter int SAMPLE_BITS   = lscd_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = lscd_pkg::FRACTION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lscd_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [SAMPLE_BITS-1:0]           sample_a,
	input  logic [SAMPLE_BITS-1:0]           sample_b,
	input  logic [SAMPLE_BITS-1:0]           sample_c,
	input  logic [SAMPLE_BITS-1:0]           sample_d,
	input  logic [SAMPLE_BITS-1:0]           sample_e,
	input  logic [SAMPLE_BITS-1:0]           sample_f,
	input  logic [SAMPLE_BITS-1:0]           sample_g,
	input  logic [SAMPLE_BITS-1:0]           sample_h,
	output logic                             out_valid,
	input  logic                             out_ready,
	output lscd_pkg::flags_t                 out_flags,
	output logic                             out_neg,
	output logic                             out_ovf,
	output logic [SAMPLE_BITS+2:0]           out_rem,
	output logic [lscd_pkg::OFFSET_W-1:0]    out_low,
	output logic [SAMPLE_BITS+2:0]           out_den
);
	import lscd_pkg::*;

	localparam int DEN_W  = SAMPLE_BITS + 3;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = WEIGHT_W + DIFF_W;
	localparam int PSUM_W = PROD_W + 2;
	localparam int ACC_W  = PSUM_W + FRACTION_BITS;
	localparam int HI_W   = ACC_W - OFFSET_W;
	localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
	localparam int TH_W   = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

	logic [SAMPLE_BITS-1:0]    smp [NUM_SAMPLES];
	logic signed [WEIGHT_W-1:0] wgt [NUM_PAIRS];
	logic signed [DIFF_W-1:0]  diff_c [NUM_PAIRS];
	logic [DEN_W-1:0]          sum_c;
	logic [COUNT_W-1:0]        lit_c;
	logic                      centred_c;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                      rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic signed [DIFF_W-1:0]  diff_s1 [NUM_PAIRS];
	logic [DEN_W-1:0]          den_s1;
	logic [COUNT_W-1:0]        lit_s1;
	logic                      centred_s1;

	logic signed [PROD_W-1:0]  prod_s2 [NUM_PAIRS];
	logic [DEN_W-1:0]          den_s2;
	flags_t                    flags_s2;

	logic signed [ACC_W-1:0]   acc_s3;
	logic [DEN_W-1:0]          den_s3;
	flags_t                    flags_s3;

	logic [ACC_W-1:0]          mag_s4;
	logic                      neg_s4;
	logic [DEN_W-1:0]          den_s4;
	flags_t                    flags_s4;

	logic [HI_W-1:0]           hi_c;
	logic                      ovf_s5;
	logic                      neg_s5;
	logic [DEN_W-1:0]          rem_s5;
	logic [OFFSET_W-1:0]       low_s5;
	logic [DEN_W-1:0]          den_s5;
	flags_t                    flags_s5;

	assign smp[0] = sample_a;
	assign smp[1] = sample_b;
	assign smp[2] = sample_c;
	assign smp[3] = sample_d;
	assign smp[4] = sample_e;
	assign smp[5] = sample_f;
	assign smp[6] = sample_g;
	assign smp[7] = sample_h;

	assign wgt[0] = cfg.weight_outer;
	assign wgt[1] = cfg.weight_second;
	assign wgt[2] = cfg.weight_third;
	assign wgt[3] = cfg.weight_inner;

	// A stage takes a new item when it is empty or its item moves on.
	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		sum_c = '0;
		lit_c = '0;
		for (int i = 0; i < NUM_SAMPLES; i++) begin
			sum_c = sum_c + DEN_W'(smp[i]);
			if (TH_W'(smp[i]) > TH_W'(cfg.line_threshold)) begin
				lit_c = lit_c + COUNT_W'(1);
			end
		end
		for (int k = 0; k < NUM_PAIRS; k++) begin
			diff_c[k] = $signed({1'b0, smp[NUM_SAMPLES-1-k]}) - $signed({1'b0, smp[k]});
		end
	end

	assign centred_c = (TH_W'(smp[2]) > TH_W'(cfg.line_threshold)) ||
		(TH_W'(smp[3]) > TH_W'(cfg.line_threshold));

	assign hi_c = mag_s4[ACC_W-1:OFFSET_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			diff_s1    <= diff_c;
			den_s1     <= sum_c;
			lit_s1     <= lit_c;
			centred_s1 <= centred_c;
		end
		if (rdy_s2) begin
			for (int k = 0; k < NUM_PAIRS; k++) begin
				prod_s2[k] <= PROD_W'(wgt[k]) * PROD_W'(diff_s1[k]);
			end
			den_s2                   <= den_s1;
			flags_s2.at_intersection <= (lit_s1 >= cfg.cross_min_count);
			flags_s2.centred         <= centred_s1;
			flags_s2.no_signal       <= (den_s1 == '0);
		end
		if (rdy_s3) begin
			acc_s3   <= (ACC_W'(prod_s2[0]) + ACC_W'(prod_s2[1]) +
				ACC_W'(prod_s2[2]) + ACC_W'(prod_s2[3])) <<< FRACTION_BITS;
			den_s3   <= den_s2;
			flags_s3 <= flags_s2;
		end
		if (rdy_s4) begin
			neg_s4   <= acc_s3[ACC_W-1];
			mag_s4   <= acc_s3[ACC_W-1] ? ACC_W'(-acc_s3) : ACC_W'(acc_s3);
			den_s4   <= den_s3;
			flags_s4 <= flags_s3;
		end
		if (rdy_s5) begin
			// The quotient fits the offset field only when the part of the magnitude
			// above it is smaller than the divisor; that part then seeds the remainder.
			ovf_s5   <= CMP_W'(hi_c) >= CMP_W'(den_s4);
			rem_s5   <= DEN_W'(hi_c);
			low_s5   <= mag_s4[OFFSET_W-1:0];
			neg_s5   <= neg_s4;
			den_s5   <= den_s4;
			flags_s5 <= flags_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_flags = flags_s5;
	assign out_neg   = neg_s5;
	assign out_ovf   = ovf_s5;
	assign out_rem   = rem_s5;
	assign out_low   = low_s5;
	assign out_den   = den_s5;

	// An empty frame has a zero divisor, so it must always take the saturation path.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && flags_s5.no_signal |-> ovf_s5)
		else $error("empty frame not marked as overflow");

endmodule

FILE: src/lscd_div_stage.sv
// One step of the restoring divider: develops one quotient bit per stage.
// Depends on lscd_pkg.
module lscd_div_stage #(
	parameter int DEN_W = lscd_pkg::SAMPLE_BITS_DEF + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lscd_pkg::flags_t              in_flags,
	input  logic                          in_neg,
	input  logic                          in_ovf,
	input  logic [DEN_W-1:0]              in_rem,
	input  logic [lscd_pkg::OFFSET_W-1:0] in_quo,
	input  logic [lscd_pkg::OFFSET_W-1:0] in_low,
	input  logic [DEN_W-1:0]              in_den,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lscd_pkg::flags_t              out_flags,
	output logic                          out_neg,
	output logic                          out_ovf,
	output logic [DEN_W-1:0]              out_rem,
	output logic [lscd_pkg::OFFSET_W-1:0] out_quo,
	output logic [lscd_pkg::OFFSET_W-1:0] out_low,
	output logic [DEN_W-1:0]              out_den
);
	import lscd_pkg::*;

	logic [DEN_W:0]      trial_c;
	logic                ge_c;
	logic                valid_q;
	flags_t              flags_q;
	logic                neg_q;
	logic                ovf_q;
	logic [DEN_W-1:0]    rem_q;
	logic [OFFSET_W-1:0] quo_q;
	logic [OFFSET_W-1:0] low_q;
	logic [DEN_W-1:0]    den_q;

	assign in_ready = !valid_q || out_ready;
	assign trial_c  = {in_rem, in_low[OFFSET_W-1]};
	assign ge_c     = trial_c >= {1'b0, in_den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			rem_q   <= ge_c ? DEN_W'(trial_c - {1'b0, in_den}) : DEN_W'(trial_c);
			quo_q   <= {in_quo[OFFSET_W-2:0], ge_c};
			low_q   <= {in_low[OFFSET_W-2:0], 1'b0};
			den_q   <= in_den;
			flags_q <= in_flags;
			neg_q   <= in_neg;
			ovf_q   <= in_ovf;
		end
	end

	assign out_valid = valid_q;
	assign out_flags = flags_q;
	assign out_neg   = neg_q;
	assign out_ovf   = ovf_q;
	assign out_rem   = rem_q;
	assign out_quo   = quo_q;
	assign out_low   = low_q;
	assign out_den   = den_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ovf_q |-> rem_q < den_q)
		else $error("partial remainder not below divisor");

endmodule
